@@ rtl/http_response_framer_top_defines.svh @@
// assertion macros for the http response framer
`ifndef HTTP_RESPONSE_FRAMER_TOP_DEFINES_SVH
`define HTTP_RESPONSE_FRAMER_TOP_DEFINES_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define HRF_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("hrf: same-cycle check failed");

// next-cycle implication, clocked on clk_i, off during reset
`define HRF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("hrf: next-cycle check failed");

`endif

@@ rtl/hrf_pkg.sv @@
// types, constants and keyword table of the http response framer
`default_nettype none

package hrf_pkg;

  localparam int unsigned LEN_W = 32;
  localparam logic [3:0] KEY_LEN = 4'd15;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef enum logic {
    PH_HEADER,
    PH_BODY
  } phase_e;

  typedef enum logic [1:0] {
    BL_NONE,
    BL_CR,
    BL_CRLF,
    BL_CRLFCR
  } blank_e;

  typedef enum logic [1:0] {
    SC_KEYWORD,
    SC_SPACE,
    SC_BLANKS,
    SC_DIGITS
  } scan_e;

  // "Content-Length:"
  function automatic logic [7:0] key_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = 8'h43;
      4'd1:    c = 8'h6F;
      4'd2:    c = 8'h6E;
      4'd3:    c = 8'h74;
      4'd4:    c = 8'h65;
      4'd5:    c = 8'h6E;
      4'd6:    c = 8'h74;
      4'd7:    c = 8'h2D;
      4'd8:    c = 8'h4C;
      4'd9:    c = 8'h65;
      4'd10:   c = 8'h6E;
      4'd11:   c = 8'h67;
      4'd12:   c = 8'h74;
      4'd13:   c = 8'h68;
      4'd14:   c = 8'h3A;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

@@ rtl/hrf_if.sv @@
// word channels of the http response framer
`default_nettype none

interface hrf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface hrf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       in_body;
  logic       message_end;
  logic       bad_length;

  modport source (output valid, output data_byte, output in_body, output message_end,
                  output bad_length, input ready);
  modport sink (input valid, input data_byte, input in_body, input message_end,
                input bad_length, output ready);
endinterface

`default_nettype wire

@@ rtl/http_response_framer_top.sv @@
// http response framer: passes bytes through with body and message-end flags
// path: an accepted word is held in the input stage, then registered into the result stage
// throughput: one word per cycle while the output side is ready; the framing state updates as each word fires
// reset: asynchronous, active low; clears both stages and returns to header scan
`default_nettype none

`include "http_response_framer_top_defines.svh"

module http_response_framer_top import hrf_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  hrf_in_if.sink      rx_i,
  hrf_out_if.source   tx_o
);

  logic             in_valid_q;
  logic [7:0]       in_byte_q;
  logic             out_valid_q;
  logic [7:0]       out_byte_q;
  logic             out_body_q;
  logic             out_end_q;
  logic             out_bad_q;

  phase_e           phase_q, phase_d;
  blank_e           blank_q, blank_d;
  scan_e            scan_q, scan_d;
  logic [3:0]       key_prog_q, key_prog_d;
  logic             closed_q, closed_d;
  logic [LEN_W-1:0] decl_len_q, decl_len_d;
  logic [LEN_W-1:0] body_rem_q, body_rem_d;

  logic             load_out;
  logic             fire;

  logic             is_digit;
  logic             is_blank;
  logic [3:0]       digit;
  logic [3:0]       key_next;
  logic             key_found;
  logic [LEN_W+3:0] acc;
  logic [LEN_W-1:0] acc_sat;
  logic             blank_done;
  logic             len_ok;

  logic             res_body;
  logic             res_end;
  logic             res_bad;

  // handshake
  assign load_out   = !out_valid_q || tx_o.ready;
  assign fire       = in_valid_q && load_out;
  assign rx_i.ready = !in_valid_q || load_out;

  // input stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (rx_i.ready) begin
      in_valid_q <= rx_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_i.ready && rx_i.valid) begin
      in_byte_q <= rx_i.rx_byte;
    end
  end

  // byte classification and digit accumulation
  always_comb begin
    is_digit  = (in_byte_q >= CH_ZERO) && (in_byte_q <= CH_NINE);
    is_blank  = (in_byte_q == CH_SPACE) || (in_byte_q == CH_TAB);
    digit     = in_byte_q[3:0];
    if ((key_prog_q < KEY_LEN) && (in_byte_q == key_char(key_prog_q))) begin
      key_next = key_prog_q + 4'd1;
    end else if (in_byte_q == key_char(4'd0)) begin
      key_next = 4'd1;
    end else begin
      key_next = 4'd0;
    end
    key_found = (key_next == KEY_LEN);
    acc = ({4'b0, decl_len_q} << 3) + ({4'b0, decl_len_q} << 1) + {{LEN_W{1'b0}}, digit};
    if (|acc[LEN_W+3:LEN_W]) begin
      acc_sat = '1;
    end else begin
      acc_sat = acc[LEN_W-1:0];
    end
  end

  // next state
  always_comb begin
    phase_d    = phase_q;
    blank_d    = blank_q;
    scan_d     = scan_q;
    key_prog_d = key_prog_q;
    closed_d   = closed_q;
    decl_len_d = decl_len_q;
    body_rem_d = body_rem_q;
    blank_done = 1'b0;
    len_ok     = 1'b0;

    if (phase_q == PH_BODY) begin
      body_rem_d = body_rem_q - LEN_W'(1);
      if (body_rem_q == LEN_W'(1)) begin
        phase_d = PH_HEADER;
      end
    end else begin
      case (scan_q)
        SC_KEYWORD: begin
          if (key_found) begin
            scan_d     = SC_SPACE;
            key_prog_d = 4'd0;
          end else begin
            key_prog_d = key_next;
          end
        end
        SC_SPACE: begin
          if (in_byte_q == CH_SPACE) begin
            scan_d = SC_BLANKS;
          end
        end
        SC_BLANKS: begin
          if (!closed_q) begin
            if (is_digit) begin
              decl_len_d = LEN_W'(digit);
              scan_d     = SC_DIGITS;
            end else if (!is_blank) begin
              closed_d = 1'b1;
            end
          end
        end
        SC_DIGITS: begin
          if (!closed_q) begin
            if (is_digit) begin
              decl_len_d = acc_sat;
            end else begin
              closed_d = 1'b1;
            end
          end
        end
        default: begin
          scan_d = SC_KEYWORD;
        end
      endcase

      case (in_byte_q)
        CH_CR: begin
          blank_d = (blank_q == BL_CRLF) ? BL_CRLFCR : BL_CR;
        end
        CH_LF: begin
          if (blank_q == BL_CR) begin
            blank_d = BL_CRLF;
          end else begin
            blank_done = (blank_q == BL_CRLFCR);
            blank_d    = BL_NONE;
          end
        end
        default: begin
          blank_d = BL_NONE;
        end
      endcase

      if (blank_done) begin
        len_ok     = (scan_d == SC_DIGITS) && (decl_len_d != '0);
        if (len_ok) begin
          phase_d    = PH_BODY;
          body_rem_d = decl_len_d;
        end
        scan_d     = SC_KEYWORD;
        key_prog_d = 4'd0;
        closed_d   = 1'b0;
        decl_len_d = '0;
      end
    end
  end

  // result flags
  always_comb begin
    res_body = (phase_q == PH_BODY);
    res_bad  = 1'b0;
    if (phase_q == PH_BODY) begin
      res_end = (body_rem_q == LEN_W'(1));
    end else begin
      res_end = blank_done && !len_ok;
      res_bad = blank_done && ((scan_q == SC_SPACE) || (scan_q == SC_BLANKS));
    end
  end

  // framing state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_HEADER;
      blank_q    <= BL_NONE;
      scan_q     <= SC_KEYWORD;
      key_prog_q <= 4'd0;
      closed_q   <= 1'b0;
      decl_len_q <= '0;
      body_rem_q <= '0;
    end else if (fire) begin
      phase_q    <= phase_d;
      blank_q    <= blank_d;
      scan_q     <= scan_d;
      key_prog_q <= key_prog_d;
      closed_q   <= closed_d;
      decl_len_q <= decl_len_d;
      body_rem_q <= body_rem_d;
    end
  end

  // result stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_byte_q <= in_byte_q;
      out_body_q <= res_body;
      out_end_q  <= res_end;
      out_bad_q  <= res_bad;
    end
  end

  assign tx_o.valid       = out_valid_q;
  assign tx_o.data_byte   = out_byte_q;
  assign tx_o.in_body     = out_body_q;
  assign tx_o.message_end = out_end_q;
  assign tx_o.bad_length  = out_bad_q;

  `HRF_ASSERT_IMPL(a_bad_ends_header, tx_o.valid && tx_o.bad_length,
                   tx_o.message_end && !tx_o.in_body)
  `HRF_ASSERT_IMPL(a_body_count_live, phase_q == PH_BODY, body_rem_q != '0)
  `HRF_ASSERT_IMPL(a_key_prog_range, in_valid_q, key_prog_q < KEY_LEN)
  `HRF_ASSERT_NEXT(a_body_last_word,
                   fire && phase_q == PH_BODY && body_rem_q == LEN_W'(1),
                   phase_q == PH_HEADER && scan_q == SC_KEYWORD)

endmodule

`default_nettype wire

@@ verif/http_response_framer_top_test.sv @@
// testbench for the http response framer: response byte streams checked against a framing predictor
`timescale 1ns / 100ps

module http_response_framer_top_test import hrf_pkg::*;;

  localparam int unsigned RUN_LIMIT    = 200000;
  localparam int unsigned TOTAL_WORDS  = 500;
  localparam int unsigned TAIL_WORDS   = 80;
  localparam int unsigned DRAIN_CYCLES = 10;
  localparam int unsigned BACKLOG_AT   = 150;
  localparam int unsigned BACKLOG_LEN  = 300;
  localparam logic [LEN_W-1:0] LEN_MAX = '1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       in_body;
    logic       message_end;
    logic       bad_length;
  } framed_word_t;

  typedef enum int {
    RESP_PLAIN,
    RESP_SIZED,
    RESP_ZERO,
    RESP_NO_DIGITS,
    RESP_SPLIT_SPACE,
    RESP_REPEATED,
    RESP_COUNT
  } resp_kind_e;

  logic clk_i;
  logic rst_ni;

  hrf_in_if  rx_if ();
  hrf_out_if tx_if ();

  http_response_framer_top i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx_if),
    .tx_o   (tx_if)
  );

  // framing state as seen by the predictor
  phase_e           hdr_phase      = PH_HEADER;
  blank_e           crlf_seen      = BL_NONE;
  logic [3:0]       key_pos        = '0;
  scan_e            len_scan       = SC_KEYWORD;
  logic             digit_run_over = 1'b0;
  logic [LEN_W-1:0] content_len    = '0;
  logic [LEN_W-1:0] body_left      = '0;
  string            key_text       = "Content-Length:";

  framed_word_t expected_words[$];
  logic [7:0]   pending_bytes[$];

  int unsigned send_gap;
  int unsigned accepted_words;
  logic        quiet_tail;
  int unsigned stall_left;
  logic        backlog_done;
  int unsigned mismatches = 0;
  int unsigned received   = 0;
  int unsigned cycle_count = 0;

  function automatic void reset_header();
    hdr_phase      = PH_HEADER;
    crlf_seen      = BL_NONE;
    key_pos        = '0;
    len_scan       = SC_KEYWORD;
    digit_run_over = 1'b0;
    content_len    = '0;
  endfunction

  function automatic void frame_byte(input logic [7:0] b);
    framed_word_t     w;
    logic [3:0]       p;
    logic [LEN_W-1:0] d;
    logic [LEN_W-1:0] len;
    logic             header_done;
    w = '0;
    w.data_byte = b;
    if (hdr_phase == PH_BODY) begin
      w.in_body = 1'b1;
      body_left = body_left - 1'b1;
      if (body_left == '0) begin
        w.message_end = 1'b1;
        reset_header();
      end
    end else begin
      case (len_scan)
        SC_KEYWORD: begin
          p = key_pos;
          if (p < KEY_LEN && b == key_text[p]) begin
            p = p + 1'b1;
          end else begin
            p = (b == key_text[0]) ? 4'd1 : 4'd0;
          end
          if (p >= KEY_LEN) begin
            len_scan = SC_SPACE;
            p = '0;
          end
          key_pos = p;
        end
        SC_SPACE: begin
          if (b == CH_SPACE) len_scan = SC_BLANKS;
        end
        SC_BLANKS: begin
          if (b >= CH_ZERO && b <= CH_NINE) begin
            content_len = LEN_W'(b - CH_ZERO);
            len_scan = SC_DIGITS;
          end else if (b != CH_SPACE && b != CH_TAB) begin
            digit_run_over = 1'b1;
          end
          // a digit after the run was closed does not count
          if (digit_run_over) len_scan = SC_BLANKS;
        end
        default: begin
          if (!digit_run_over) begin
            if (b >= CH_ZERO && b <= CH_NINE) begin
              d = LEN_W'(b - CH_ZERO);
              if (content_len > (LEN_MAX - d) / 10) begin
                content_len = LEN_MAX;
              end else begin
                content_len = content_len * 10 + d;
              end
            end else begin
              digit_run_over = 1'b1;
            end
          end
        end
      endcase

      header_done = 1'b0;
      case (b)
        CH_CR: begin
          if (crlf_seen == BL_CRLF) crlf_seen = BL_CRLFCR;
          else crlf_seen = BL_CR;
        end
        CH_LF: begin
          header_done = (crlf_seen == BL_CRLFCR);
          if (crlf_seen == BL_CR) crlf_seen = BL_CRLF;
          else crlf_seen = BL_NONE;
        end
        default: crlf_seen = BL_NONE;
      endcase

      if (header_done) begin
        len = '0;
        if (len_scan == SC_SPACE || len_scan == SC_BLANKS) begin
          w.bad_length = 1'b1;
        end else if (len_scan == SC_DIGITS) begin
          len = content_len;
        end
        reset_header();
        if (len == '0) begin
          w.message_end = 1'b1;
        end else begin
          hdr_phase = PH_BODY;
          body_left = len;
        end
      end
    end
    expected_words.push_back(w);
  endfunction

  function automatic void push_text(input string s);
    for (int k = 0; k < s.len(); k++) pending_bytes.push_back(s[k]);
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    rst_ni <= 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // response stream
  initial begin
    string       eol;
    string       hdr;
    int unsigned body_len;
    int unsigned n;
    int          i;
    resp_kind_e  kind;
    eol = "\015\012";

    pending_bytes.push_back(8'h00);
    pending_bytes.push_back(8'hFF);
    push_text({eol, eol});
    push_text({"Content-Length: 1", eol, eol, "Z"});

    // every kind once, then a random mix
    for (i = 0; pending_bytes.size() < TOTAL_WORDS; i++) begin
      if (i < RESP_COUNT) kind = resp_kind_e'(i);
      else kind = resp_kind_e'($urandom_range(0, RESP_COUNT - 1));
      hdr = "";
      body_len = 0;
      n = $urandom_range(1, 24);
      if ($urandom_range(0, 1)) hdr = {"HTTP/1.1 200 OK", eol};
      if ($urandom_range(0, 3) == 0) hdr = {hdr, $sformatf("X-%0d: v", $urandom_range(0, 99)), eol};
      if ($urandom_range(0, 3) == 0) hdr = {hdr, "Conte"};
      case (kind)
        RESP_SIZED: begin
          body_len = n;
          hdr = {hdr, "Content-Length: "};
          if ($urandom_range(0, 1)) hdr = {hdr, "\t "};
          if ($urandom_range(0, 3) == 0) hdr = {hdr, "00"};
          hdr = {hdr, $sformatf("%0d", n)};
          if ($urandom_range(0, 2) == 0) hdr = {hdr, ";q"};
          hdr = {hdr, eol};
        end
        RESP_ZERO: begin
          if ($urandom_range(0, 1)) hdr = {hdr, "Content-Length: 0", eol};
          else hdr = {hdr, "Content-Length: \t000", eol};
        end
        RESP_NO_DIGITS: begin
          case ($urandom_range(0, 4))
            0: hdr = {hdr, "Content-Length:", eol};
            1: hdr = {hdr, "Content-Length: none", eol};
            2: hdr = {hdr, "Content-Length: x7", eol};
            3: hdr = {hdr, "Content-Length:", eol, "Server: x", eol};
            default: hdr = {hdr, "Content-Length: ", eol};
          endcase
        end
        RESP_SPLIT_SPACE: begin
          body_len = $urandom_range(1, 9);
          hdr = {hdr, "Content-Length:", eol, $sformatf("Age: %0d", body_len), eol};
        end
        RESP_REPEATED: begin
          body_len = n;
          hdr = {hdr, $sformatf("Content-Length: %0d", n), eol, "Content-Length: 99", eol};
        end
        default: hdr = {hdr, "Server: x", eol};
      endcase
      push_text({hdr, eol});
      repeat (body_len) pending_bytes.push_back(8'($urandom_range(0, 255)));

      // junk and broken blank lines between responses
      if ($urandom_range(0, 4) == 0) begin
        case ($urandom_range(0, 2))
          0: repeat ($urandom_range(1, 8)) pending_bytes.push_back(8'($urandom_range(0, 255)));
          1: push_text("\015\015\012\012");
          default: push_text({"\012", eol, "C"});
        endcase
      end
    end

    // saturating length last, since its body never ends
    if ($urandom_range(0, 1)) hdr = {"Content-Length: 99999999999", eol, eol};
    else hdr = {"Content-Length: 4294967296", eol, eol};
    push_text(hdr);
    repeat (6) pending_bytes.push_back(8'($urandom_range(0, 255)));
  end

  // sender
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_if.valid    <= 1'b0;
      rx_if.rx_byte  <= '0;
      send_gap       <= 0;
      accepted_words <= 0;
      quiet_tail     <= 1'b0;
    end else if (!rx_if.valid || rx_if.ready) begin
      if (rx_if.valid) begin
        frame_byte(rx_if.rx_byte);
        accepted_words <= accepted_words + 1;
      end
      quiet_tail <= (pending_bytes.size() <= TAIL_WORDS);
      if (send_gap != 0) begin
        send_gap    <= send_gap - 1;
        rx_if.valid <= 1'b0;
      end else if (pending_bytes.size() != 0) begin
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= pending_bytes.pop_front();
        if (pending_bytes.size() > TAIL_WORDS && $urandom_range(0, 9) == 0) begin
          send_gap <= $urandom_range(1, 19);
        end
      end else begin
        rx_if.valid <= 1'b0;
      end
    end
  end

  // receiver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tx_if.ready  <= 1'b0;
      stall_left   <= 0;
      backlog_done <= 1'b0;
    end else if (stall_left != 0) begin
      tx_if.ready <= 1'b0;
      stall_left  <= stall_left - 1;
    end else if (!backlog_done && accepted_words >= BACKLOG_AT) begin
      // long hold so the block fills up and pushes back
      tx_if.ready  <= 1'b0;
      stall_left   <= BACKLOG_LEN - 1;
      backlog_done <= 1'b1;
    end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
      tx_if.ready <= 1'b0;
      stall_left  <= $urandom_range(0, 18);
    end else begin
      tx_if.ready <= 1'b1;
    end
  end

  // output check
  always @(posedge clk_i) begin
    framed_word_t got;
    framed_word_t want;
    if (rst_ni && tx_if.valid && tx_if.ready) begin
      got = {tx_if.data_byte, tx_if.in_body, tx_if.message_end, tx_if.bad_length};
      if (expected_words.size() == 0) begin
        if (mismatches < 10) begin
          $display("word %0d unexpected: data %02h body %0b end %0b bad %0b", received,
                   got.data_byte, got.in_body, got.message_end, got.bad_length);
        end
        mismatches++;
      end else begin
        want = expected_words.pop_front();
        if (got.data_byte !== want.data_byte || got.in_body !== want.in_body ||
            got.message_end !== want.message_end || got.bad_length !== want.bad_length) begin
          if (mismatches < 10) begin
            $display("word %0d expected data %02h body %0b end %0b bad %0b", received,
                     want.data_byte, want.in_body, want.message_end, want.bad_length);
            $display("word %0d actual   data %02h body %0b end %0b bad %0b", received,
                     got.data_byte, got.in_body, got.message_end, got.bad_length);
          end
          mismatches++;
        end
      end
      received++;
    end
  end

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= RUN_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    do @(posedge clk_i);
    while (pending_bytes.size() != 0 || rx_if.valid !== 1'b0 || expected_words.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
